// ===== rtl/esrg_pkg.sv =====
// esrg_pkg: shared types, constants and the easing table function for the
// eased speed ramp generator. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package esrg_pkg;

	localparam int COS_TAB_DEPTH = 256;
	localparam int TI_W          = $clog2(COS_TAB_DEPTH + 1);
	localparam int IW            = $clog2(COS_TAB_DEPTH);
	localparam int DIV_STEPS     = 48;
	localparam int DCNT_W        = $clog2(DIV_STEPS + 1);
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SET  = 2'd1,
		CMD_STOP = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ACCEL  = 2'd0,
		REG_EASING = 2'd1,
		REG_ATTACH = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		EASE_LINEAR = 2'd0,
		EASE_SMOOTH = 2'd1,
		EASE_SMOOTHER = 2'd2,
		EASE_SINE = 2'd3
	} ease_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_DECIDE, ST_DIV, ST_E1, ST_E2, ST_E3, ST_E4,
		ST_SCALE, ST_APPLY, ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        now_ms;
		logic signed [23:0] target_rpm;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] speed_rpm;
		logic               drive_update;
		logic               stop_motor;
		logic               still_ramping;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic decide;
		logic div_fin;
		logic e1;
		logic e2;
		logic e3;
		logic e4;
		logic scale;
		logic apply;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic is_set;
	} dp_stat_t;

	// sin^2 table entry in q1.16, sine from an 11th order taylor series in q30
	function automatic logic [16:0] ease_tab_val(input int unsigned idx);
		longint unsigned y, y2, term, s;
		longint sum;
		y = (PI_Q30 * longint'(idx)) / (2 * COS_TAB_DEPTH);
		y2 = (y * y) >> 30;
		term = y;
		sum = longint'(y);
		for (int k = 1; k <= 5; k++) begin
			term = (term * y2) >> 30;
			case (k)
				1: term = term / 6;
				2: term = term / 20;
				3: term = term / 42;
				4: term = term / 72;
				default: term = term / 110;
			endcase
			if (k[0]) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
		s = longint'(sum);
		return 17'((s * s + (64'd1 << 43)) >> 44);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/esrg_div.sv =====
// esrg_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on esrg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module esrg_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] dividend,
	input  wire logic [35:0] divisor,
	output logic             done,
	output logic      [47:0] quotient
);
	import esrg_pkg::*;

	logic [47:0]       dvd_q;
	logic [35:0]       rem_q;
	logic [35:0]       dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [36:0]       trial;
	logic              ge;

	assign trial = {rem_q, dvd_q[47]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - DCNT_W'(1);
			busy_q <= cnt_q != DCNT_W'(1);
			done_q <= cnt_q == DCNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 36'(trial - {1'b0, dvs_q}) : trial[35:0];
			dvd_q <= {dvd_q[46:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

// ===== rtl/esrg_ctrl.sv =====
// esrg_ctrl: sequencer for one item and the output valid flag.
// Depends on esrg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module esrg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire esrg_pkg::dp_stat_t stat,
	output esrg_pkg::ctrl_cmd_t    cmd
);
	import esrg_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = stat.need_div ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.div_fin = 1'b1;
					state_d = stat.is_set ? ST_FINISH : ST_E1;
				end
			end
			ST_E1: begin
				cmd.e1 = 1'b1;
				state_d = ST_E2;
			end
			ST_E2: begin
				cmd.e2 = 1'b1;
				state_d = ST_E3;
			end
			ST_E3: begin
				cmd.e3 = 1'b1;
				state_d = ST_E4;
			end
			ST_E4: begin
				cmd.e4 = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q) else $error("result not presented after load");
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !stat.div_done) |=> state_q == ST_DIV)
		else $error("left divide before quotient done");
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_PREP) else $error("accept lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.out_load) else $error("result overwritten");
endmodule
`default_nettype wire

// ===== rtl/esrg_dp.sv =====
// esrg_dp: ramp state, configuration registers, easing arithmetic and result
// register. Depends on esrg_pkg and esrg_div.
`timescale 1ns / 1ps
`default_nettype none
module esrg_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire esrg_pkg::in_item_t  in_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [23:0]         cfg_data,
	input  wire esrg_pkg::ctrl_cmd_t cmd,
	output esrg_pkg::dp_stat_t       stat,
	output esrg_pkg::out_item_t      out_data
);
	import esrg_pkg::*;

	// configuration
	logic [23:0] acc_q;
	logic [1:0]  mode_q;
	logic        attached_q;
	// ramp state
	logic signed [23:0] cur_q, tgt_q, start_spd_q;
	logic [31:0] start_time_q, dur_q;
	logic        ramp_q;
	// item and per-item work registers
	logic [1:0]  icmd_q;
	logic [31:0] inow_q;
	logic signed [23:0] itgt_q;
	logic [23:0] mag_q;
	logic        dneg_q;
	logic [31:0] elapsed_q;
	logic        drive_q, stop_q, noact_q;
	logic [49:0] b_q;
	logic [33:0] a_q;
	logic [19:0] qv_q;
	logic [52:0] m_q;
	logic [16:0] e_q;
	logic [40:0] s_q;
	out_item_t   out_q;

	logic [16:0] ease_tab [0:COS_TAB_DEPTH];
	for (genvar g = 0; g <= COS_TAB_DEPTH; g++) begin : g_tab
		localparam logic [16:0] TAB_VAL = ease_tab_val(g);
		assign ease_tab[g] = TAB_VAL;
	end

	// divider hookup
	logic        div_start, div_done;
	logic [47:0] dividend, quotient;
	logic [35:0] divisor;
	logic [33:0] num;
	logic        jump;

	esrg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dividend),
		.divisor(divisor), .done(div_done), .quotient(quotient)
	);

	assign num  = 34'(mag_q) * 34'd1000;
	assign jump = (dur_q == '0) || (elapsed_q >= dur_q);
	always_comb begin
		stat.is_set   = icmd_q == CMD_SET;
		stat.div_done = div_done;
		if (icmd_q == CMD_SET) stat.need_div = (mag_q != '0) && !(num < 34'(acc_q));
		else if (icmd_q == CMD_TICK) stat.need_div = attached_q && ramp_q && !jump;
		else stat.need_div = 1'b0;
	end
	assign div_start = cmd.decide && stat.need_div;
	assign dividend  = (icmd_q == CMD_SET) ? 48'({num, 1'b0} + 35'(acc_q))
	                                      : {elapsed_q, 16'd0};
	assign divisor   = (icmd_q == CMD_SET) ? 36'({acc_q, 1'b0}) : 36'(dur_q);

	// easing operands
	logic [15:0]         p;
	logic [16+IW-1:0]    x;
	logic [IW-1:0]       ti;
	logic [15:0]         tf;
	logic [TI_W-1:0]     ti0, ti1;
	logic [24:0]         dsp;
	logic [32:0]         cfac;
	logic [20:0]         qsum;
	logic [24:0]         step;

	assign p    = quotient[15:0];
	assign x    = (16+IW)'(p) * (16+IW)'(COS_TAB_DEPTH);
	assign ti   = x[16 +: IW];
	assign tf   = x[15:0];
	assign ti0  = TI_W'(ti);
	assign ti1  = TI_W'(ti) + TI_W'(1);
	assign dsp  = (icmd_q == CMD_SET) ? 25'(itgt_q) - 25'(cur_q) : 25'(tgt_q) - 25'(start_spd_q);
	assign cfac = 33'((b_q[47:0] + 48'd32768) >> 16);
	assign qsum = 21'((35'({a_q[31:0], 2'b0}) + 35'({a_q[31:0], 1'b0}) + 35'd32768) >> 16)
	            + 21'd655360 - 21'(20'(p) * 20'd15);
	assign step = 25'((s_q + 41'd32768) >> 16);

	function automatic logic [16:0] clamp1(input logic [52:0] v);
		return (v > 53'(ONE_Q16)) ? ONE_Q16 : v[16:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 24'd25600;
			mode_q      <= EASE_LINEAR;
			attached_q  <= 1'b1;
			cur_q       <= '0;
			tgt_q       <= '0;
			start_spd_q <= '0;
			start_time_q <= '0;
			dur_q       <= '0;
			ramp_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACCEL:  if (cfg_data != '0) acc_q <= cfg_data;
					REG_EASING: mode_q <= cfg_data[1:0];
					REG_ATTACH: begin
						attached_q <= cfg_data[0];
						if (!cfg_data[0]) ramp_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.decide) begin
				case (icmd_q)
					CMD_SET: begin
						tgt_q        <= itgt_q;
						start_spd_q  <= cur_q;
						start_time_q <= inow_q;
						dur_q        <= '0;
						ramp_q       <= mag_q != '0;
					end
					CMD_STOP: begin
						tgt_q       <= '0;
						cur_q       <= '0;
						start_spd_q <= '0;
						dur_q       <= '0;
						ramp_q      <= 1'b0;
					end
					CMD_TICK: begin
						if (attached_q && ramp_q && jump) begin
							cur_q  <= tgt_q;
							ramp_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.div_fin && icmd_q == CMD_SET) begin
				dur_q  <= (quotient[47:32] != '0) ? '1 : quotient[31:0];
				ramp_q <= 1'b1;
			end
			if (cmd.apply)
				cur_q <= dneg_q ? 24'(start_spd_q - 24'(step)) : 24'(start_spd_q + 24'(step));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			icmd_q <= in_data.cmd;
			inow_q <= in_data.now_ms;
			itgt_q <= in_data.target_rpm;
		end
		if (cmd.prep) begin
			dneg_q    <= dsp[24];
			mag_q     <= dsp[24] ? 24'(-dsp) : dsp[23:0];
			elapsed_q <= inow_q - start_time_q;
		end
		if (cmd.decide) begin
			drive_q <= (icmd_q == CMD_TICK) && attached_q && ramp_q;
			noact_q <= (icmd_q == CMD_TICK) && !(attached_q && ramp_q);
			stop_q  <= (icmd_q == CMD_STOP) && attached_q;
		end
		if (cmd.e1) begin
			if (mode_q == EASE_SINE) a_q <= 34'(ease_tab[ti0]) * 34'(ONE_Q16 - 17'(tf));
			else a_q <= 34'(32'(p) * 32'(p));
		end
		if (cmd.e2) begin
			case (mode_q)
				EASE_SMOOTH:   b_q <= 50'(a_q[31:0]) * 50'(18'd196608 - 18'({p, 1'b0}));
				EASE_SMOOTHER: b_q <= 50'(a_q[31:0]) * 50'(p);
				EASE_SINE:     b_q <= 50'(a_q) + 50'(34'(ease_tab[ti1]) * 34'(tf)) + 50'd32768;
				default:       b_q <= 50'(p);
			endcase
			qv_q <= qsum[19:0];
		end
		if (cmd.e3)
			m_q <= 53'(cfac) * 53'(qv_q);
		if (cmd.e4) begin
			case (mode_q)
				EASE_SMOOTH:   e_q <= clamp1(53'((b_q + 50'h80000000) >> 32));
				EASE_SMOOTHER: e_q <= clamp1((m_q + (53'd1 << 47)) >> 48);
				EASE_SINE:     e_q <= clamp1(53'(b_q >> 16));
				default:       e_q <= clamp1(53'(b_q));
			endcase
		end
		if (cmd.scale)
			s_q <= 41'(mag_q) * 41'(e_q);
		if (cmd.out_load) begin
			out_q.speed_rpm     <= cur_q;
			out_q.drive_update  <= drive_q;
			out_q.stop_motor    <= stop_q;
			out_q.still_ramping <= noact_q ? 1'b0 : ramp_q;
		end
	end

	assign out_data = out_q;
endmodule
`default_nettype wire

// ===== rtl/eased_speed_ramp_generator_core.sv =====
// eased_speed_ramp_generator_core: top level, joins the sequencer and the
// datapath. Depends on esrg_pkg, esrg_ctrl, esrg_dp.
// accept to result: stop, unknown command, a set target with no divide and ticks that
// end or skip a ramp pass prep and decide; a set target that divides adds the divide,
// a ramp tick the divide and easing; the next item is taken in the cycle after the load
// asynchronous active-low reset restores register defaults and clears ramp and control state
`timescale 1ns / 1ps
`default_nettype none
module eased_speed_ramp_generator_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item transaction in
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire esrg_pkg::in_item_t in_data,
	// result transaction out
	output logic                    out_valid,
	input  wire logic               out_ready,
	output esrg_pkg::out_item_t     out_data,
	// register write transaction
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);
	import esrg_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// register writes are taken only while idle with no item arriving
	assign cfg_ready = in_ready && !in_valid;

	// sequencer: walks prep, decide, divide and the easing steps
	esrg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	// datapath: ramp state, divider, easing math, result register
	esrg_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
		.out_data(out_data)
	);
endmodule
`default_nettype wire
